// File: hdl/oale_pkg.sv
// Shared types and constants for the ordered array list engine.
// No dependencies; imported by oale_cell, oale_match_encoder and the top level.
package oale_pkg;

   localparam int DEPTH       = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int POS_W       = 7;
   localparam int CFG_W       = 7;
   localparam int KEY_FIELD_W = 32;
   localparam int MPOS_W      = 6;
   localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int GRP         = 8;
   localparam int GRP_IDX_W   = $clog2(GRP);
   localparam int NGRP        = (DEPTH + GRP - 1) / GRP;

   typedef enum logic [2:0] {
      OP_APPEND    = 3'd0,
      OP_INSERT    = 3'd1,
      OP_REMOVE    = 3'd2,
      OP_READ      = 3'd3,
      OP_OVERWRITE = 3'd4,
      OP_SEARCH    = 3'd5,
      OP_CLEAR     = 3'd6
   } op_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                 apply;
      op_type               op;
      logic [POS_W-1:0]     pos;
      logic [CNT_W-1:0]     count;
      logic [KEY_WIDTH-1:0] key;
   } cell_cmd_type;

endpackage

// File: hdl/ordered_array_list_engine.sv
// Ordered array list engine: a row of DEPTH cells with a sequencer, APB-style
// capacity register and a registered result stage. Depends on oale_pkg,
// oale_cell and oale_match_encoder.
// A request is accepted in ST_IDLE and executed in ST_EXEC; a search goes on
// through ST_SCAN and ST_FINISH while the first-match encoder works. No new
// request is taken until the result stage is loaded, which waits on rsp_tready.
// Reset: synchronous; clears the entry count, sets capacity to 64, leaves keys.
module ordered_array_list_engine
   import oale_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] operation, [9:3] position, [41:10] key_in, [47:42] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] ok, [32:1] key_out, [33] found, [39:34] match_position,
   // [46:40] entry_count, [47] is_empty, [48] is_full, [55:49] zero
   output logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] CSR_CAPACITY_ADDR = 3'd0;
   localparam logic [CFG_W-1:0] CAP_RESET   = CFG_W'(64);

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_FINISH} state_type;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CFG_W-1:0]       cap_ff, cap_in;
   logic                   search_ok_ff, search_ok_in;
   logic [DEPTH-1:0]       match_vec_ff, match_vec_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   ok_ff, ok_in;
   logic [KEY_FIELD_W-1:0] key_out_ff, key_out_in;
   logic                   found_ff, found_in;
   logic [MPOS_W-1:0]      mpos_ff, mpos_in;
   logic [POS_W-1:0]       ecount_ff, ecount_in;
   logic                   empty_ff, empty_in;
   logic                   full_ff, full_in;

   cell_cmd_type           cmd;
   logic [KEY_WIDTH-1:0]   cell_key [DEPTH];
   logic [KEY_WIDTH-1:0]   lower_key [DEPTH];
   logic [KEY_WIDTH-1:0]   upper_key [DEPTH];
   logic [KEY_WIDTH-1:0]   cell_rd [DEPTH];
   logic [DEPTH-1:0]       cell_match;
   logic [KEY_WIDTH-1:0]   rd_any;
   logic                   enc_found;
   logic [IDX_W-1:0]       enc_pos;

   logic [CMP_W-1:0]       cnt_x, pos_x, lim_x, new_cnt_x;
   logic                   out_free, op_ok, csr_write;

   // cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_lo
         assign lower_key[i] = '0;
      end else begin : g_lo
         assign lower_key[i] = cell_key[i-1];
      end
      if (i == DEPTH - 1) begin : g_hi
         assign upper_key[i] = '0;
      end else begin : g_hi
         assign upper_key[i] = cell_key[i+1];
      end
      oale_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(i)),
         .lower_key  (lower_key[i]),
         .upper_key  (upper_key[i]),
         .key        (cell_key[i]),
         .match_bit  (cell_match[i]),
         .rd_data    (cell_rd[i])
      );
   end

   oale_match_encoder u_enc (
      .clock     (clock),
      .match_vec (match_vec_ff),
      .found     (enc_found),
      .match_pos (enc_pos)
   );

   always_comb begin
      rd_any = '0;
      for (int i = 0; i < DEPTH; i++) rd_any = rd_any | cell_rd[i];
   end

   // capacity register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign cap_in     = (csr_write && csr_paddr == CSR_CAPACITY_ADDR) ?
                       csr_pwdata[CFG_W-1:0] : cap_ff;
   assign csr_prdata = (csr_paddr == CSR_CAPACITY_ADDR) ? 32'(cap_ff) : '0;

   assign cnt_x    = CMP_W'(count_ff);
   assign pos_x    = CMP_W'(pos_ff);
   assign lim_x    = (CMP_W'(cap_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      op_ok     = 1'b0;
      new_cnt_x = cnt_x;
      unique case (op_ff)
         OP_APPEND: begin
            op_ok     = cnt_x < lim_x;
            new_cnt_x = cnt_x + CMP_W'(1);
         end
         OP_INSERT: begin
            op_ok     = (cnt_x < lim_x) && (pos_x <= cnt_x);
            new_cnt_x = cnt_x + CMP_W'(1);
         end
         OP_REMOVE: begin
            op_ok     = pos_x < cnt_x;
            new_cnt_x = cnt_x - CMP_W'(1);
         end
         OP_READ:      op_ok = pos_x < cnt_x;
         OP_OVERWRITE: op_ok = pos_x < cnt_x;
         OP_SEARCH:    op_ok = pos_x <= lim_x;
         OP_CLEAR: begin
            op_ok     = 1'b1;
            new_cnt_x = '0;
         end
         default: op_ok = 1'b0;
      endcase
      if (!op_ok) new_cnt_x = cnt_x;
   end

   always_comb begin
      cmd.apply = (state_ff == ST_EXEC) && (op_ff != OP_SEARCH) && out_free && op_ok;
      cmd.op    = op_ff;
      cmd.pos   = pos_ff;
      cmd.count = count_ff;
      cmd.key   = key_ff;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      search_ok_in = search_ok_ff;
      match_vec_in = match_vec_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ok_in        = ok_ff;
      key_out_in   = key_out_ff;
      found_in     = found_ff;
      mpos_in      = mpos_ff;
      ecount_in    = ecount_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = op_type'(req_tdata[2:0]);
               pos_in   = req_tdata[9:3];
               key_in   = req_tdata[10 +: KEY_WIDTH];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff == OP_SEARCH) begin
               search_ok_in = op_ok;
               match_vec_in = cell_match;
               state_in     = ST_SCAN;
            end else if (out_free) begin
               count_in     = CNT_W'(new_cnt_x);
               rsp_valid_in = 1'b1;
               ok_in        = op_ok;
               key_out_in   = (op_ff == OP_READ && op_ok) ? KEY_FIELD_W'(rd_any) : '0;
               found_in     = 1'b0;
               mpos_in      = '0;
               ecount_in    = POS_W'(new_cnt_x);
               empty_in     = new_cnt_x == '0;
               full_in      = new_cnt_x >= lim_x;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               ok_in        = search_ok_ff;
               key_out_in   = '0;
               found_in     = search_ok_ff && enc_found;
               mpos_in      = (search_ok_ff && enc_found) ? MPOS_W'(enc_pos) : '0;
               ecount_in    = POS_W'(count_ff);
               empty_in     = cnt_x == '0;
               full_in      = cnt_x >= lim_x;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      search_ok_ff <= search_ok_in;
      match_vec_ff <= match_vec_in;
      ok_ff        <= ok_in;
      key_out_ff   <= key_out_in;
      found_ff     <= found_in;
      mpos_ff      <= mpos_in;
      ecount_ff    <= ecount_in;
      empty_ff     <= empty_in;
      full_ff      <= full_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, full_ff, empty_ff, ecount_ff, mpos_ff, found_ff,
                        key_out_ff, ok_ff};

endmodule

// File: hdl/oale_cell.sv
// One list entry: holds a key, shifts to/from its neighbours, compares locally.
// Depends on oale_pkg.
module oale_cell
   import oale_pkg::*;
(
   input  logic                 clock,
   input  cell_cmd_type         cmd,
   input  logic [IDX_W-1:0]     cell_index,
   input  logic [KEY_WIDTH-1:0] lower_key,
   input  logic [KEY_WIDTH-1:0] upper_key,
   output logic [KEY_WIDTH-1:0] key,
   output logic                 match_bit,
   output logic [KEY_WIDTH-1:0] rd_data
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic [CMP_W-1:0]     idx_x;
   logic [CMP_W-1:0]     pos_x;
   logic [CMP_W-1:0]     cnt_x;

   assign idx_x = CMP_W'(cell_index);
   assign pos_x = CMP_W'(cmd.pos);
   assign cnt_x = CMP_W'(cmd.count);

   always_comb begin
      key_in = key_ff;
      if (cmd.apply) begin
         unique case (cmd.op)
            OP_APPEND: begin
               if (idx_x == cnt_x) key_in = cmd.key;
            end
            OP_INSERT: begin
               if (idx_x == pos_x) key_in = cmd.key;
               else if (idx_x > pos_x && idx_x <= cnt_x) key_in = lower_key;
            end
            OP_REMOVE: begin
               if (idx_x >= pos_x && (idx_x + CMP_W'(1)) < cnt_x) key_in = upper_key;
            end
            OP_OVERWRITE: begin
               if (idx_x == pos_x) key_in = cmd.key;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key       = key_ff;
   assign match_bit = (key_ff == cmd.key) && (idx_x >= pos_x) && (idx_x < cnt_x);
   assign rd_data   = (idx_x == pos_x) ? key_ff : '0;

endmodule

// File: hdl/oale_match_encoder.sv
// First-match encoder over the cell match vector: registered per-group stage,
// then a final pick across groups. Depends on oale_pkg.
module oale_match_encoder
   import oale_pkg::*;
(
   input  logic              clock,
   input  logic [DEPTH-1:0]  match_vec,
   output logic              found,
   output logic [IDX_W-1:0]  match_pos
);

   logic [NGRP*GRP-1:0]  padded;
   logic                 grp_any_ff [NGRP];
   logic                 grp_any_in [NGRP];
   logic [GRP_IDX_W-1:0] grp_idx_ff [NGRP];
   logic [GRP_IDX_W-1:0] grp_idx_in [NGRP];

   assign padded = (NGRP*GRP)'(match_vec);

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = |padded[g*GRP +: GRP];
         grp_idx_in[g] = '0;
         for (int j = GRP - 1; j >= 0; j--) begin
            if (padded[g*GRP + j]) grp_idx_in[g] = GRP_IDX_W'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_ff[g] <= grp_any_in[g];
         grp_idx_ff[g] <= grp_idx_in[g];
      end
   end

   always_comb begin
      found     = 1'b0;
      match_pos = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            found     = 1'b1;
            match_pos = IDX_W'(g*GRP) + IDX_W'(grp_idx_ff[g]);
         end
      end
   end

endmodule
